/* rtl/core/scaler_sum_spill_detector_assert.svh */
// Assertion macros for the scaler sum and spill detector.
// Included by the top level; no other dependencies.
`ifndef SCALER_SUM_SPILL_DETECTOR_ASSERT_SVH
`define SCALER_SUM_SPILL_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssd assertion failed");
// next-cycle implication
`define SSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssd assertion failed");
`else
`define SSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SSD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/ssd_pkg.sv */
// Shared types and constants of the scaler sum and spill detector.
// No dependencies.
`default_nettype none
package ssd_pkg;
    localparam int CHANNELS_DEF = 8;
    localparam int CH_W         = 3;
    localparam int COUNT_W      = 32;
    localparam int NUM_COUNTS   = 4;
    localparam int RATIO_W      = 8;
    localparam int LIMIT_W      = COUNT_W + RATIO_W;
    localparam int QUEUE_DEPTH  = 2;
    localparam int IN_TDATA_W   = 136;
    localparam int OUT_TDATA_W  = 168;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd10;
    localparam logic [CH_W-1:0]    CH_NUM      = 3'd1;
    localparam logic [CH_W-1:0]    CH_DEN      = 3'd5;

    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic [CH_W-1:0]              channel;
        t_count [NUM_COUNTS-1:0]      counts;
        logic                         in_range;
        logic                         is_ch5;
        logic                         decide;
        logic                         last;
        t_count                       ch1_count;
        logic [LIMIT_W-1:0]           limit;
        t_count                       evt_ch5;
    } t_work;

    typedef struct packed {
        logic                         spill_on;
        t_count                       spill_time;
        t_count [NUM_COUNTS-1:0]      sums;
        logic [CH_W-1:0]              channel;
        logic                         done;
    } t_result;
endpackage
`default_nettype wire

/* rtl/core/ssd_front.sv */
// Front end: accepts items, tracks channel 1/5 counts, forms the spill limit.
// Depends on ssd_pkg.
`default_nettype none
module ssd_front import ssd_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic                  i_s_axis_tuser,
    input  wire logic                  i_s_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [RATIO_W-1:0]    i_cfg_data,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output t_work                      o_work
);
    logic [RATIO_W-1:0] r_spill_ratio;
    t_count r_last_ch1, r_last_ch5, r_evt_ch5;
    t_count n_last_ch1, n_last_ch5, n_evt_ch5;
    logic [CH_W-1:0] w_ch;
    t_count w_cnt0;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;
    assign w_ch            = i_s_axis_tdata[CH_W-1:0];
    assign w_cnt0          = i_s_axis_tdata[CH_W +: COUNT_W];

    always_comb begin
        n_last_ch1 = (w_ch == CH_NUM) ? w_cnt0 : r_last_ch1;
        n_last_ch5 = (w_ch == CH_DEN) ? w_cnt0 : r_last_ch5;
        n_evt_ch5  = (w_ch == CH_DEN) ? w_cnt0 : r_evt_ch5;

        o_work.channel = w_ch;
        for (int k = 0; k < NUM_COUNTS; k++) begin
            o_work.counts[k] = i_s_axis_tdata[CH_W + k*COUNT_W +: COUNT_W];
        end
        o_work.in_range  = ({{(32-CH_W){1'b0}}, w_ch} < 32'(CHANNELS));
        o_work.is_ch5    = (w_ch == CH_DEN);
        o_work.decide    = i_s_axis_tlast && i_s_axis_tuser;
        o_work.last      = i_s_axis_tlast;
        o_work.ch1_count = n_last_ch1;
        o_work.limit     = LIMIT_W'(r_spill_ratio) * LIMIT_W'(n_last_ch5);
        o_work.evt_ch5   = n_evt_ch5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spill_ratio <= RATIO_RESET;
            r_last_ch1    <= '0;
            r_last_ch5    <= '0;
            r_evt_ch5     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_spill_ratio <= i_cfg_data;
            end
            if (o_push) begin
                r_last_ch1 <= n_last_ch1;
                r_last_ch5 <= n_last_ch5;
                r_evt_ch5  <= i_s_axis_tlast ? '0 : n_evt_ch5;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/ssd_queue.sv */
// Short FIFO between front and back ends.
// Depends on ssd_pkg.
`default_nettype none
module ssd_queue import ssd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_work  i_work,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_work       o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_work r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [LVL_W-1:0] r_level;

    assign o_full  = (r_level == LVL_W'(DEPTH));
    assign o_valid = (r_level != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/ssd_back.sv */
// Back end: per-channel sum update, spill decision, output register.
// Depends on ssd_pkg.
`default_nettype none
module ssd_back import ssd_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  wire t_work                  i_work,
    output logic                        o_pop,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                        o_m_axis_tlast
);
    localparam int ROWS  = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
    localparam int IDX_W = $clog2(ROWS);
    localparam int PAD_W = OUT_TDATA_W - 1 - COUNT_W - NUM_COUNTS*COUNT_W - CH_W;

    t_count [NUM_COUNTS-1:0] r_sums [ROWS];
    logic [ROWS-1:0]         r_row_valid;
    t_count                  r_spill_cnt, n_spill_cnt;
    logic                    r_spill_state, n_spill_state;
    logic                    r_out_valid;
    t_result                 r_out;

    logic [IDX_W-1:0]        w_idx;
    t_count [NUM_COUNTS-1:0] w_old, w_new;
    logic                    w_now;

    assign o_pop = i_q_valid && (!r_out_valid || i_m_axis_tready);
    assign w_idx = i_work.channel[IDX_W-1:0];

    always_comb begin
        w_old = '0;
        if (i_work.in_range && r_row_valid[w_idx]) begin
            w_old = r_sums[w_idx];
        end
        for (int k = 0; k < NUM_COUNTS; k++) begin
            w_new[k] = w_old[k] + i_work.counts[k];
        end

        w_now         = ({{RATIO_W{1'b0}}, i_work.ch1_count} > i_work.limit);
        n_spill_cnt   = r_spill_cnt + (i_work.is_ch5 ? i_work.counts[0] : '0);
        n_spill_state = r_spill_state;
        if (i_work.decide) begin
            if (w_now && !r_spill_state) begin
                n_spill_cnt = i_work.evt_ch5;
            end
            n_spill_state = w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_work.in_range) begin
            r_sums[w_idx] <= w_new;
        end
        if (o_pop) begin
            r_out.channel    <= i_work.channel;
            r_out.sums       <= i_work.in_range ? w_new : '0;
            r_out.spill_time <= n_spill_cnt;
            r_out.spill_on   <= n_spill_state;
            r_out.done       <= i_work.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid   <= '0;
            r_spill_cnt   <= '0;
            r_spill_state <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_work.in_range) begin
                    r_row_valid[w_idx] <= 1'b1;
                end
                r_spill_cnt   <= n_spill_cnt;
                r_spill_state <= n_spill_state;
                r_out_valid   <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out.done;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out.spill_on, r_out.spill_time,
                              r_out.sums, r_out.channel};
endmodule
`default_nettype wire

/* rtl/core/scaler_sum_spill_detector.sv */
// Top level of the scaler sum and spill detector: front end, queue, back end.
// Depends on ssd_pkg, ssd_front, ssd_queue, ssd_back and the assertion header.
//
//   channel   direction  handshake                   payload
//   s_axis    in         i_s_axis_tvalid/o_..tready  tdata, tuser, tlast
//   m_axis    out        o_m_axis_tvalid/i_..tready  tdata, tlast
//   cfg       in         i_cfg_valid/o_cfg_ready     spill ratio
//
// One item per cycle unless m_axis stalls. An item is queued; the back end's
// read-add-write of channel sums sets the rate and loads the output register.
// Synchronous active-low reset; sums read as zero until a channel is written.
// A two-entry queue takes input while the output stalls, until it is full.
`default_nettype none
`include "scaler_sum_spill_detector_assert.svh"
module scaler_sum_spill_detector import ssd_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // channel, count_a, count_b, count_c, count_d, zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // scaler_event
    input  wire logic                   i_s_axis_tuser,
    input  wire logic                   i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // channel_out, sum_a, sum_b, sum_c, sum_d, spill_time, spill_on, zero pad
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                        o_m_axis_tlast,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [RATIO_W-1:0]     i_cfg_data
);
    logic  w_push, w_pop, w_q_full, w_q_valid;
    t_work w_work_in, w_work_head;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] w_q_level;

    ssd_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_work          (w_work_in)
    );

    ssd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_work_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_work_head),
        .o_level (w_q_level)
    );

    ssd_back #(.CHANNELS(CHANNELS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_work          (w_work_head),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    `SSD_ASSERT_NXT(a_accept_queued, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, w_q_level != '0)
    `SSD_ASSERT_IMP(a_result_from_queue, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(w_q_level) != '0)
endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for scaler_sum_spill_detector: directed and random channel records,
// expected sums and spill state from an in-bench predictor, random stalls on both streams.
// Depends on ssd_pkg and the scaler_sum_spill_detector RTL.
module testbench;
    import ssd_pkg::*;

    localparam int NCH         = CHANNELS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 105;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [COUNT_W-1:0] count_a;
        logic [COUNT_W-1:0] count_b;
        logic [COUNT_W-1:0] count_c;
        logic [COUNT_W-1:0] count_d;
        logic               scaler;
        logic               last;
    } t_rec;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [COUNT_W-1:0] sum_a;
        logic [COUNT_W-1:0] sum_b;
        logic [COUNT_W-1:0] sum_c;
        logic [COUNT_W-1:0] sum_d;
        logic [COUNT_W-1:0] spill_time;
        logic               spill_on;
        logic               done;
    } t_sums;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [RATIO_W-1:0]     cfg_data = '0;

    // predictor state
    logic [COUNT_W-1:0] run_sum [0:NCH-1][0:NUM_COUNTS-1];
    logic [COUNT_W-1:0] last_ch1 = '0;
    logic [COUNT_W-1:0] last_ch5 = '0;
    logic [COUNT_W-1:0] evt_ch5 = '0;
    logic [COUNT_W-1:0] spill_cnt = '0;
    logic               spill_flag = 1'b0;
    logic [RATIO_W-1:0] ratio_reg = RATIO_RESET;

    t_rec  records_to_send[$];
    t_sums expected_sums[$];
    t_rec  cur_rec;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    scaler_sum_spill_detector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        for (int c = 0; c < NCH; c++)
            for (int k = 0; k < NUM_COUNTS; k++)
                run_sum[c][k] = '0;
    end

    function automatic int unsigned draw_wait();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
    endfunction

    function automatic logic [COUNT_W-1:0] draw_count();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 255);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic predict_channel_sums(input t_rec r);
        t_sums e;
        logic [63:0] lim;
        logic now;
        e = '0;
        e.channel = r.channel;
        if (r.channel < NCH) begin
            run_sum[r.channel][0] += r.count_a;
            run_sum[r.channel][1] += r.count_b;
            run_sum[r.channel][2] += r.count_c;
            run_sum[r.channel][3] += r.count_d;
            e.sum_a = run_sum[r.channel][0];
            e.sum_b = run_sum[r.channel][1];
            e.sum_c = run_sum[r.channel][2];
            e.sum_d = run_sum[r.channel][3];
        end
        if (r.channel == CH_NUM)
            last_ch1 = r.count_a;
        if (r.channel == CH_DEN) begin
            last_ch5 = r.count_a;
            spill_cnt += r.count_a;
            evt_ch5 = r.count_a;
        end
        if (r.last && r.scaler) begin
            lim = 64'(ratio_reg) * 64'(last_ch5);
            now = 64'(last_ch1) > lim;
            if (now && !spill_flag)
                spill_cnt = evt_ch5;
            spill_flag = now;
        end
        e.spill_time = spill_cnt;
        e.spill_on = spill_flag;
        e.done = r.last;
        if (r.last)
            evt_ch5 = '0;
        expected_sums.push_back(e);
    endtask

    task automatic report_mismatch(input string field, input logic [COUNT_W-1:0] got,
                                   input logic [COUNT_W-1:0] want);
        if (mismatches < 40)
            $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready)
                predict_channel_sums(cur_rec);
            if (!s_valid || o_s_axis_tready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (records_to_send.size() > 0) begin
                    cur_rec = records_to_send.pop_front();
                    s_tdata <= {5'b0, cur_rec.count_d, cur_rec.count_c, cur_rec.count_b,
                                cur_rec.count_a, cur_rec.channel};
                    s_tuser <= cur_rec.scaler;
                    s_tlast <= cur_rec.last;
                    s_valid <= 1'b1;
                    send_wait = draw_wait();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_sums got;
        t_sums want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                got.channel    = o_m_axis_tdata[0 +: CH_W];
                got.sum_a      = o_m_axis_tdata[3 +: COUNT_W];
                got.sum_b      = o_m_axis_tdata[35 +: COUNT_W];
                got.sum_c      = o_m_axis_tdata[67 +: COUNT_W];
                got.sum_d      = o_m_axis_tdata[99 +: COUNT_W];
                got.spill_time = o_m_axis_tdata[131 +: COUNT_W];
                got.spill_on   = o_m_axis_tdata[163];
                got.done       = o_m_axis_tlast;
                if (expected_sums.size() == 0) begin
                    report_mismatch("unexpected item", got.sum_a, '0);
                end else begin
                    want = expected_sums.pop_front();
                    if (got.channel !== want.channel)
                        report_mismatch("channel_out", COUNT_W'(got.channel),
                                        COUNT_W'(want.channel));
                    if (got.sum_a !== want.sum_a)
                        report_mismatch("sum_a", got.sum_a, want.sum_a);
                    if (got.sum_b !== want.sum_b)
                        report_mismatch("sum_b", got.sum_b, want.sum_b);
                    if (got.sum_c !== want.sum_c)
                        report_mismatch("sum_c", got.sum_c, want.sum_c);
                    if (got.sum_d !== want.sum_d)
                        report_mismatch("sum_d", got.sum_d, want.sum_d);
                    if (got.spill_time !== want.spill_time)
                        report_mismatch("spill_time", got.spill_time, want.spill_time);
                    if (got.spill_on !== want.spill_on)
                        report_mismatch("spill_on", COUNT_W'(got.spill_on),
                                        COUNT_W'(want.spill_on));
                    if (got.done !== want.done)
                        report_mismatch("event_done", COUNT_W'(got.done), COUNT_W'(want.done));
                end
                recv_wait = draw_wait();
            end
            if (recv_wait != 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("[scaler_sum_spill_detector] ERROR");
            $finish;
        end
    end

    task automatic push_rec(input logic [CH_W-1:0] ch, input logic [COUNT_W-1:0] a,
                            input logic [COUNT_W-1:0] b, input logic [COUNT_W-1:0] c,
                            input logic [COUNT_W-1:0] d, input logic scaler, input logic last);
        t_rec r;
        r.channel = ch;
        r.count_a = a;
        r.count_b = b;
        r.count_c = c;
        r.count_d = d;
        r.scaler = scaler;
        r.last = last;
        records_to_send.push_back(r);
    endtask

    task automatic add_noise();
        push_rec(CH_W'($urandom_range(0, 7)), draw_count(), draw_count(), draw_count(),
                 draw_count(), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    endtask

    // well-formed event; ch1 lands near ratio * ch5 so spill toggles often
    task automatic add_event(input logic [RATIO_W-1:0] ratio, output int unsigned n);
        logic scaler;
        logic full_seq;
        logic [COUNT_W-1:0] ch5_val;
        logic [COUNT_W-1:0] ch1_val;
        logic [COUNT_W-1:0] a;
        logic [63:0] v;
        logic [CH_W-1:0] ch;
        scaler = $urandom_range(0, 3) != 0;
        full_seq = 1'($urandom_range(0, 1));
        n = full_seq ? NCH : $urandom_range(1, 6);
        case ($urandom_range(0, 3))
            0: ch5_val = '0;
            1: ch5_val = $urandom_range(0, 1000);
            2: ch5_val = $urandom;
            default: ch5_val = '1;
        endcase
        v = 64'(ratio) * 64'(ch5_val) + 64'($urandom_range(0, 4));
        v = (v < 2) ? 64'd0 : v - 2;
        ch1_val = (v > 64'hFFFF_FFFF) ? '1 : v[COUNT_W-1:0];
        if ($urandom_range(0, 3) == 0)
            ch1_val = draw_count();
        for (int i = 0; i < n; i++) begin
            ch = full_seq ? CH_W'(i) : CH_W'($urandom_range(0, 7));
            a = draw_count();
            if (ch == CH_NUM)
                a = ch1_val;
            if (ch == CH_DEN)
                a = ch5_val;
            push_rec(ch, a, draw_count(), draw_count(), draw_count(), scaler, i == n - 1);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (records_to_send.size() != 0 || s_valid || expected_sums.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_ratio(input logic [RATIO_W-1:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        ratio_reg = v;
    endtask

    task automatic fill_random(input logic [RATIO_W-1:0] ratio);
        int unsigned n;
        int unsigned k;
        n = 0;
        while (n < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                add_noise();
                n++;
            end else begin
                add_event(ratio, k);
                n += k;
            end
        end
    endtask

    initial begin
        logic [RATIO_W-1:0] ratios [5];
        ratios[0] = 8'd1;
        ratios[1] = 8'd255;
        ratios[2] = 8'd0;
        ratios[3] = RATIO_W'($urandom_range(2, 254));
        ratios[4] = RATIO_W'($urandom_range(2, 254));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset ratio of 10
        push_rec(3'd0, '1, '1, '1, '1, 1'b0, 1'b0);
        push_rec(3'd0, 32'd1, 32'd1, 32'd1, 32'd1, 1'b0, 1'b0);   // sums wrap to zero
        push_rec(3'd0, '0, '0, '0, '0, 1'b1, 1'b1);
        push_rec(3'd7, '1, 32'hAAAA_AAAA, 32'h5555_5555, '1, 1'b0, 1'b1);
        push_rec(3'd1, 32'd1000, '0, '0, '0, 1'b1, 1'b0);
        push_rec(3'd5, 32'd100, '0, '0, '0, 1'b1, 1'b1);           // equal to limit: off
        push_rec(3'd1, 32'd1001, '0, '0, '0, 1'b1, 1'b0);
        push_rec(3'd5, 32'd100, '0, '0, '0, 1'b1, 1'b1);           // spill turns on
        push_rec(3'd5, '1, '0, '0, '0, 1'b0, 1'b0);                // counter wraps
        push_rec(3'd5, 32'd5, '0, '0, '0, 1'b0, 1'b1);             // non-scaler end
        push_rec(3'd1, '0, '0, '0, '0, 1'b1, 1'b1);                // spill off
        push_rec(3'd5, '0, '0, '0, '0, 1'b1, 1'b0);
        push_rec(3'd1, 32'd1, '0, '0, '0, 1'b1, 1'b1);             // zero ch5 count
        push_rec(3'd1, '0, '0, '0, '0, 1'b1, 1'b1);
        push_rec(3'd1, '1, '0, '0, '0, 1'b1, 1'b1);                // no ch5 in event
        push_rec(3'd2, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, 1'b0);
        push_rec(3'd3, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 1'b0);
        push_rec(3'd4, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, '1, 1'b0, 1'b0);
        push_rec(3'd6, 32'h1234_5678, 32'h9ABC_DEF0, '1, '0, 1'b0, 1'b1);
        push_rec(3'd5, '1, '0, '0, '0, 1'b1, 1'b0);
        push_rec(3'd1, '1, '0, '0, '0, 1'b1, 1'b1);                // full-scale compare
        push_rec(3'd0, '0, '0, '0, '0, 1'b1, 1'b1);
        fill_random(ratio_reg);
        wait_drained();

        foreach (ratios[p]) begin
            write_ratio(ratios[p]);
            fill_random(ratios[p]);
            wait_drained();
        end

        if (mismatches == 0)
            $display("[scaler_sum_spill_detector] OK");
        else
            $display("[scaler_sum_spill_detector] ERROR");
        $finish;
    end
endmodule
